// ----- design/disk_request_scheduler_defines.svh -----
// Assertion macros used by the checker module of the scheduler.
`ifndef DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define DISK_REQUEST_SCHEDULER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define DRS_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("scheduler check failed");

// Property that must hold in the cycle after its trigger.
`define DRS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("scheduler check failed");

`endif

// ----- design/dsched_pkg.sv -----
package dsched_pkg;

  localparam int ARR_W  = 16;
  localparam int MODE_W = 3;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_FIFO  = 3'd0;
  localparam mode_t MODE_SSTF  = 3'd1;
  localparam mode_t MODE_LOOK  = 3'd2;
  localparam mode_t MODE_CLOOK = 3'd3;
  localparam mode_t MODE_FLOOK = 3'd4;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic by_queue;
    logic filt_en;
    logic filt_down;
    logic key_zero;
    logic key_track;
    logic active_q;
  } pick_ctrl_t;

endpackage

// ----- design/disk_request_scheduler.sv -----
// Add: a full table goes straight to the output; otherwise a serial search of the
// used flags finds the lowest free slot.
// Get: one scan reads the whole slot memory; LOOK, FLOOK and C-LOOK may scan twice.
// One item is in work at a time; a result waits in the output register.
// Synchronous reset empties the table, sets direction up, queue one, mode FIFO.
module disk_request_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TRACK_BITS  = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [ID_BITS-1:0]    req_id,
  input  logic [TRACK_BITS-1:0] req_track,
  input  logic [TRACK_BITS-1:0] head_track,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  grant_valid,
  output logic [ID_BITS-1:0]    grant_id,
  output logic [TRACK_BITS-1:0] grant_track,
  output logic                  moving_down,
  output logic                  still_pending,
  output logic                  add_dropped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [dsched_pkg::MODE_W-1:0] cfg_data
);
  import dsched_pkg::*;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = ID_BITS + TRACK_BITS + ARR_W + 1;

  state_t state, state_next;

  mode_t                 policy_mode;
  logic                  going_down;
  logic                  active_queue;
  logic [ARR_W-1:0]      arr_cnt;
  logic                  used [QUEUE_DEPTH];
  logic [CNT_W-1:0]      used_cnt;
  logic [CNT_W-1:0]      qcnt0;
  logic [CNT_W-1:0]      qcnt1;
  logic [CNT_W-1:0]      idx;
  logic                  pass2;
  logic                  op_func;
  logic [ID_BITS-1:0]    op_id;
  logic [TRACK_BITS-1:0] op_track;
  logic [TRACK_BITS-1:0] op_head;

  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_used;

  logic                  res_gv;
  logic [ID_BITS-1:0]    res_id;
  logic [TRACK_BITS-1:0] res_track;
  logic                  res_down;
  logic                  res_pending;
  logic                  res_dropped;

  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  pick_ctrl_t            pctrl;
  logic                  found;
  logic [IDX_W-1:0]      best_idx;
  logic [ID_BITS-1:0]    best_id;
  logic [TRACK_BITS-1:0] best_track;
  logic                  best_queue;

  logic                  accept;
  logic                  full;
  logic                  aq_new;
  logic                  aq_empty;
  logic                  skip_scan;
  logic                  is_look;
  logic                  restart;
  logic                  free_hit;
  logic                  last_idx;
  logic                  out_load;
  logic                  gd_final;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign full      = (used_cnt == CNT_W'(QUEUE_DEPTH));
  assign is_look   = (policy_mode == MODE_LOOK) || (policy_mode == MODE_FLOOK);
  assign free_hit  = !used[idx[IDX_W-1:0]];
  assign last_idx  = (idx == CNT_W'(QUEUE_DEPTH - 1));
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  assign restart   = !found && !pass2 &&
                     (is_look || (policy_mode == MODE_CLOOK));

  // FLOOK swaps queues first when the active one has nothing left.
  always_comb begin
    aq_new   = active_queue;
    if (policy_mode == MODE_FLOOK) begin
      if ((active_queue ? qcnt1 : qcnt0) == '0) begin
        aq_new = !active_queue;
      end
    end
    aq_empty  = ((aq_new ? qcnt1 : qcnt0) == '0);
    skip_scan = ((policy_mode == MODE_FLOOK) && aq_empty) ||
                ((policy_mode == MODE_LOOK) && (used_cnt == '0));
  end

  always_comb begin
    gd_final = going_down;
    if (found) begin
      case (policy_mode)
        MODE_LOOK, MODE_FLOOK: gd_final = going_down;
        MODE_CLOOK:            gd_final = pass2;
        default: begin
          if (best_track > op_head) begin
            gd_final = 1'b0;
          end else if (best_track < op_head) begin
            gd_final = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    pctrl          = '0;
    pctrl.clear    = (accept && (func == FUNC_GET)) || ((state == ST_EVAL) && restart);
    pctrl.sample   = rd_pend;
    pctrl.active_q = active_queue;
    case (policy_mode)
      MODE_SSTF: begin
      end
      MODE_LOOK: begin
        pctrl.filt_en   = 1'b1;
        pctrl.filt_down = going_down;
      end
      MODE_FLOOK: begin
        pctrl.filt_en   = 1'b1;
        pctrl.filt_down = going_down;
        pctrl.by_queue  = 1'b1;
      end
      MODE_CLOOK: begin
        pctrl.filt_en   = !pass2;
        pctrl.key_track = pass2;
      end
      default: begin
        pctrl.key_zero = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = {!active_queue, arr_cnt, op_track, op_id};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_ADD) begin
            state_next = full ? ST_OUT : ST_FREE;
          end else begin
            state_next = skip_scan ? ST_OUT : ST_SCAN;
          end
        end
      end
      ST_FREE: begin
        if (free_hit) begin
          ram_we     = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = restart ? ST_SCAN : ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= MODE_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      policy_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      going_down   <= 1'b0;
      active_queue <= 1'b1;
      arr_cnt      <= '0;
      used_cnt     <= '0;
      qcnt0        <= '0;
      qcnt1        <= '0;
      rd_pend      <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        used[i] <= 1'b0;
      end
    end else begin
      rd_pend <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (accept && (func == FUNC_GET)) begin
            active_queue <= aq_new;
          end
        end
        ST_FREE: begin
          if (free_hit) begin
            used[idx[IDX_W-1:0]] <= 1'b1;
            used_cnt <= used_cnt + 1'b1;
            arr_cnt  <= arr_cnt + 1'b1;
            if (active_queue) begin
              qcnt0 <= qcnt0 + 1'b1;
            end else begin
              qcnt1 <= qcnt1 + 1'b1;
            end
          end
        end
        ST_EVAL: begin
          if (restart) begin
            if (is_look) begin
              going_down <= !going_down;
            end
          end else begin
            going_down <= gd_final;
            if (found) begin
              used[best_idx] <= 1'b0;
              used_cnt <= used_cnt - 1'b1;
              if (best_queue) begin
                qcnt1 <= qcnt1 - 1'b1;
              end else begin
                qcnt0 <= qcnt0 - 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scan index, operand capture and the pending result.
  always_ff @(posedge clk) begin
    rd_idx  <= idx[IDX_W-1:0];
    rd_used <= used[idx[IDX_W-1:0]];
    case (state)
      ST_IDLE: begin
        idx   <= '0;
        pass2 <= 1'b0;
        if (accept) begin
          op_func     <= func;
          op_id       <= req_id;
          op_track    <= req_track;
          op_head     <= head_track;
          res_gv      <= 1'b0;
          res_id      <= '0;
          res_track   <= '0;
          res_down    <= going_down;
          res_dropped <= (func == FUNC_ADD) && full;
          res_pending <= (func == FUNC_ADD) ? 1'b1 : (used_cnt != '0);
        end
      end
      ST_FREE, ST_SCAN: begin
        idx <= idx + 1'b1;
      end
      ST_EVAL: begin
        idx <= '0;
        if (restart) begin
          pass2 <= 1'b1;
        end else begin
          res_gv      <= found;
          res_id      <= found ? best_id : '0;
          res_track   <= found ? best_track : '0;
          res_down    <= gd_final;
          res_pending <= (used_cnt != CNT_W'(found));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      grant_valid   <= res_gv;
      grant_id      <= res_id;
      grant_track   <= res_track;
      moving_down   <= res_down;
      still_pending <= res_pending;
      add_dropped   <= res_dropped;
    end
  end

  dsched_slot_ram #(
    .ADDR_W(IDX_W),
    .DATA_W(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx[IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  dsched_pick #(
    .IDX_W     (IDX_W),
    .TRACK_BITS(TRACK_BITS),
    .ID_BITS   (ID_BITS)
  ) u_pick (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (pctrl),
    .cand_used   (rd_used && (op_func == FUNC_GET)),
    .cand_idx    (rd_idx),
    .cand_id     (ram_rdata[ID_BITS-1:0]),
    .cand_track  (ram_rdata[ID_BITS +: TRACK_BITS]),
    .cand_arrival(ram_rdata[ID_BITS + TRACK_BITS +: ARR_W]),
    .cand_queue  (ram_rdata[ENTRY_W-1]),
    .head        (op_head),
    .arr_cnt     (arr_cnt),
    .found       (found),
    .best_idx    (best_idx),
    .best_id     (best_id),
    .best_track  (best_track),
    .best_queue  (best_queue)
  );

endmodule

// ----- design/dsched_slot_ram.sv -----
module dsched_slot_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 49
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/dsched_pick.sv -----
module dsched_pick #(
  parameter int IDX_W      = 4,
  parameter int TRACK_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsched_pkg::pick_ctrl_t ctrl,
  input  logic                   cand_used,
  input  logic [IDX_W-1:0]       cand_idx,
  input  logic [ID_BITS-1:0]     cand_id,
  input  logic [TRACK_BITS-1:0]  cand_track,
  input  logic [dsched_pkg::ARR_W-1:0] cand_arrival,
  input  logic                   cand_queue,
  input  logic [TRACK_BITS-1:0]  head,
  input  logic [dsched_pkg::ARR_W-1:0] arr_cnt,
  output logic                   found,
  output logic [IDX_W-1:0]       best_idx,
  output logic [ID_BITS-1:0]     best_id,
  output logic [TRACK_BITS-1:0]  best_track,
  output logic                   best_queue
);
  import dsched_pkg::*;

  logic [TRACK_BITS-1:0] best_key;
  logic [ARR_W-1:0]      best_age;
  logic [TRACK_BITS-1:0] seek_dist;
  logic [TRACK_BITS-1:0] key;
  logic [ARR_W-1:0]      age;
  logic                  in_dir;
  logic                  eligible;
  logic                  wins;

  always_comb begin
    seek_dist = (cand_track >= head) ? (cand_track - head) : (head - cand_track);
    if (ctrl.key_zero) begin
      key = '0;
    end else if (ctrl.key_track) begin
      key = cand_track;
    end else begin
      key = seek_dist;
    end
    age = arr_cnt - cand_arrival;
    // A track equal to the head lies in either direction.
    in_dir = ctrl.filt_down ? (cand_track <= head) : (cand_track >= head);
    eligible = cand_used && (!ctrl.by_queue || (cand_queue == ctrl.active_q)) &&
               (!ctrl.filt_en || in_dir);
    wins = !found || (key < best_key) || ((key == best_key) && (age > best_age));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.sample && eligible && wins) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample && eligible && wins && !ctrl.clear) begin
      best_idx   <= cand_idx;
      best_id    <= cand_id;
      best_track <= cand_track;
      best_queue <= cand_queue;
      best_key   <= key;
      best_age   <= age;
    end
  end

endmodule

// ----- design/dsched_checker.sv -----
`include "disk_request_scheduler_defines.svh"

module dsched_checker #(
  parameter int TRACK_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  grant_valid,
  input logic [ID_BITS-1:0]    grant_id,
  input logic [TRACK_BITS-1:0] grant_track,
  input logic                  still_pending,
  input logic                  add_dropped
);

  // A waiting result keeps its identity until the transfer.
  `DRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(grant_id))

  // A grant and a drop never come from the same item.
  `DRS_ASSERT_SAME(a_grant_xor_drop, out_valid, !(grant_valid && add_dropped))

  // Without a grant the request fields read zero.
  `DRS_ASSERT_SAME(a_empty_zero, out_valid && !grant_valid,
                   (grant_id == '0) && (grant_track == '0))

  // A drop means the table was full, so requests remain.
  `DRS_ASSERT_SAME(a_drop_pending, out_valid && add_dropped, still_pending)

endmodule

bind disk_request_scheduler dsched_checker #(
  .TRACK_BITS(TRACK_BITS),
  .ID_BITS   (ID_BITS)
) u_dsched_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .grant_valid  (grant_valid),
  .grant_id     (grant_id),
  .grant_track  (grant_track),
  .still_pending(still_pending),
  .add_dropped  (add_dropped)
);

// ----- sim/disk_request_scheduler_test.sv -----
module disk_request_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dsched_pkg::*;

  localparam int DEPTH = 16;
  localparam int MAX_CYCLES = 900000;
  localparam int EXP_SLOTS = 64;
  localparam mode_t MODE_SPARE_LO = 3'd5;
  localparam mode_t MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic        gv;
    logic [15:0] gid;
    logic [15:0] gtr;
    logic        down;
    logic        pend;
    logic        drop;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_ADD;
  logic [15:0] req_id = '0;
  logic [15:0] req_track = '0;
  logic [15:0] head_track = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic grant_valid;
  logic [15:0] grant_id;
  logic [15:0] grant_track;
  logic moving_down;
  logic still_pending;
  logic add_dropped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MODE_W-1:0] cfg_data = '0;

  disk_request_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .req_id(req_id),
    .req_track(req_track), .head_track(head_track),
    .out_valid(out_valid), .out_ready(out_ready), .grant_valid(grant_valid),
    .grant_id(grant_id), .grant_track(grant_track), .moving_down(moving_down),
    .still_pending(still_pending), .add_dropped(add_dropped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the request table.
  logic        used_q [DEPTH];
  logic [15:0] id_q [DEPTH];
  logic [15:0] track_q [DEPTH];
  logic [15:0] arrive_q [DEPTH];
  logic        queue_q [DEPTH];
  logic        dir_down;
  logic        act_queue;
  logic [15:0] arrive_cnt;
  logic [MODE_W-1:0] policy;

  // Expected results in order; the sender and the checker each own one pointer.
  grant_t exp_store [EXP_SLOTS];
  int wr_ptr = 0;
  int rd_ptr = 0;
  int errors = 0;
  int cycles = 0;
  bit long_hold = 1'b0;
  bit rx_stall_on = 1'b1;
  bit tx_gaps_on = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [15:0] age(input int i);
    return arrive_cnt - arrive_q[i];
  endfunction

  function automatic bit better(input int i, input logic [16:0] ki, input int b,
                                input logic [16:0] kb);
    if (b < 0) return 1'b1;
    if (ki != kb) return ki < kb;
    return age(i) > age(b);
  endfunction

  function automatic logic [16:0] seek(input logic [15:0] t, input logic [15:0] h);
    return (t >= h) ? {1'b0, t - h} : {1'b0, h - t};
  endfunction

  function automatic bit eligible(input int i, input bit by_q);
    return used_q[i] && (!by_q || queue_q[i] == act_queue);
  endfunction

  function automatic int scan_side(input bit by_q, input logic [15:0] h, input bit down);
    int b;
    logic [16:0] bd;
    b = -1;
    bd = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!eligible(i, by_q)) continue;
      if (down ? (track_q[i] > h) : (track_q[i] < h)) continue;
      if (better(i, seek(track_q[i], h), b, bd)) begin
        b = i;
        bd = seek(track_q[i], h);
      end
    end
    return b;
  endfunction

  function automatic int sweep(input bit by_q, input logic [15:0] h);
    int p;
    p = scan_side(by_q, h, dir_down);
    if (p < 0) begin
      dir_down = ~dir_down;
      p = scan_side(by_q, h, dir_down);
    end
    return p;
  endfunction

  // kind 0 oldest, 1 nearest, 2 lowest track
  function automatic int best_by(input logic [15:0] h, input int kind);
    int b;
    logic [16:0] bk, k;
    b = -1;
    bk = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!used_q[i]) continue;
      k = (kind == 0) ? 17'd0 : (kind == 1) ? seek(track_q[i], h) : {1'b0, track_q[i]};
      if (better(i, k, b, bk)) begin
        b = i;
        bk = k;
      end
    end
    return b;
  endfunction

  function automatic bit any_left(input bit by_q);
    for (int i = 0; i < DEPTH; i++)
      if (eligible(i, by_q)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void turn_toward(input logic [15:0] t, input logic [15:0] h);
    if (t > h) dir_down = 1'b0;
    if (t < h) dir_down = 1'b1;
  endfunction

  function automatic grant_t schedule(input logic f, input logic [15:0] rid,
                                      input logic [15:0] rt, input logic [15:0] h);
    grant_t g;
    int p, slot;
    g = '0;
    p = -1;
    if (f == FUNC_ADD) begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (!used_q[i] && slot < 0) slot = i;
      if (slot < 0) begin
        g.drop = 1'b1;
      end else begin
        used_q[slot] = 1'b1;
        id_q[slot] = rid;
        track_q[slot] = rt;
        arrive_q[slot] = arrive_cnt;
        queue_q[slot] = ~act_queue;
        arrive_cnt++;
      end
    end else begin
      case (policy)
        MODE_SSTF: begin
          p = best_by(h, 1);
          if (p >= 0) turn_toward(track_q[p], h);
        end
        MODE_LOOK: begin
          if (any_left(1'b0)) p = sweep(1'b0, h);
        end
        MODE_CLOOK: begin
          p = scan_side(1'b0, h, 1'b0);
          if (p >= 0) begin
            dir_down = 1'b0;
          end else begin
            p = best_by(h, 2);
            if (p >= 0) dir_down = 1'b1;
          end
        end
        MODE_FLOOK: begin
          if (!any_left(1'b1)) act_queue = ~act_queue;
          if (any_left(1'b1)) p = sweep(1'b1, h);
        end
        default: begin
          p = best_by(h, 0);
          if (p >= 0) turn_toward(track_q[p], h);
        end
      endcase
      if (p >= 0) begin
        g.gv = 1'b1;
        g.gid = id_q[p];
        g.gtr = track_q[p];
        used_q[p] = 1'b0;
      end
    end
    g.down = dir_down;
    g.pend = any_left(1'b0);
    return g;
  endfunction

  // Valid stays high between items sent back to back; it drops in a gap.
  task automatic send_request(input logic f, input logic [15:0] rid, input logic [15:0] rt,
                              input logic [15:0] h);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    func <= f;
    req_id <= rid;
    req_track <= rt;
    head_track <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    exp_store[wr_ptr % EXP_SLOTS] = schedule(f, rid, rt, h);
    wr_ptr++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic set_policy(input logic [MODE_W-1:0] m);
    idle_input();
    wait (wr_ptr == rd_ptr);
    repeat (2 * (DEPTH + 2) + 8) @(negedge clk);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    policy = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    grant_t w, r;
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      r = {grant_valid, grant_id, grant_track, moving_down, still_pending, add_dropped};
      if (wr_ptr == rd_ptr) begin
        report("unexpected transfer", r[31:0], 32'd0);
      end else begin
        w = exp_store[rd_ptr % EXP_SLOTS];
        rd_ptr++;
        if (r.gv != w.gv) report("grant_valid", 32'(r.gv), 32'(w.gv));
        if (r.gid != w.gid) report("grant_id", 32'(r.gid), 32'(w.gid));
        if (r.gtr != w.gtr) report("grant_track", 32'(r.gtr), 32'(w.gtr));
        if (r.down != w.down) report("moving_down", 32'(r.down), 32'(w.down));
        if (r.pend != w.pend) report("still_pending", 32'(r.pend), 32'(w.pend));
        if (r.drop != w.drop) report("add_dropped", 32'(r.drop), 32'(w.drop));
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(negedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else if (!rx_stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [15:0] pick_track();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    set_policy(MODE_FIFO);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h1234);
    send_request(FUNC_ADD, 16'hffff, 16'hffff, 16'h0);
    send_request(FUNC_ADD, 16'h0000, 16'h0000, 16'hffff);
    send_request(FUNC_ADD, 16'h5555, 16'h8000, 16'h0);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h8000);
    set_policy(MODE_SSTF);
    send_request(FUNC_ADD, 16'haaaa, 16'h7000, 16'h0);
    send_request(FUNC_ADD, 16'h1111, 16'h9000, 16'h0);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h8000);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h8000);
    set_policy(MODE_LOOK);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h8000);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h0);
    set_policy(MODE_CLOOK);
    send_request(FUNC_ADD, 16'h2222, 16'h0010, 16'h0);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'hffff);
    set_policy(MODE_FLOOK);
    send_request(FUNC_ADD, 16'h3333, 16'h0020, 16'h0);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h0020);
    send_request(FUNC_GET, 16'h0, 16'h0, 16'h0020);
    set_policy(MODE_SPARE_HI);
    // Fill the table past its depth so the last adds are dropped.
    for (int i = 0; i < DEPTH + 2; i++) send_request(FUNC_ADD, 16'(i), 16'h0100, 16'h0);
    for (int i = 0; i < DEPTH + 1; i++) send_request(FUNC_GET, 16'h0, 16'h0, 16'h0100);
  endtask

  task automatic test_random_policy(input logic [MODE_W-1:0] m, input int n);
    int fill;
    set_policy(m);
    for (int i = 0; i < n; i++) begin
      fill = 0;
      foreach (used_q[k]) fill += used_q[k];
      // Bias toward adds when sparse and gets when crowded.
      if (int'($urandom_range(0, DEPTH)) >= fill + ((i % 64 < 32) ? 2 : -2))
        send_request(FUNC_ADD, 16'($urandom), pick_track(), 16'($urandom));
      else
        send_request(FUNC_GET, 16'($urandom), 16'($urandom), pick_track());
    end
  endtask

  task automatic test_back_pressure();
    set_policy(MODE_LOOK);
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_request(i[0] ? FUNC_GET : FUNC_ADD, 16'($urandom), 16'($urandom),
                     16'($urandom));
    join
  endtask

  task automatic test_smooth_flow();
    rx_stall_on = 1'b0;
    tx_gaps_on = 1'b0;
    test_random_policy(MODE_SSTF, 100);
    rx_stall_on = 1'b1;
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    foreach (used_q[i]) begin
      used_q[i] = 1'b0;
      id_q[i] = '0;
      track_q[i] = '0;
      arrive_q[i] = '0;
      queue_q[i] = 1'b0;
    end
    dir_down = 1'b0;
    act_queue = 1'b1;
    arrive_cnt = '0;
    policy = MODE_FIFO;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_back_pressure();
    test_smooth_flow();
    for (int r = 0; r < 2; r++) begin
      test_random_policy(MODE_FIFO, 120);
      test_random_policy(MODE_SSTF, 120);
      test_random_policy(MODE_LOOK, 120);
      test_random_policy(MODE_CLOOK, 120);
      test_random_policy(MODE_FLOOK, 120);
    end
    test_random_policy(MODE_SPARE_LO, 40);
    idle_input();
    wait (wr_ptr == rd_ptr);
    repeat (2 * (DEPTH + 2) + 10) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
